/* rtl/jkm_pkg.sv */
// ----------------------------------------------------------------------------
// jkm_pkg: shared definitions for the joystick axis key mapper
// Command codes, mode codes, event and key codes, register indexes, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package jkm_pkg;

    // Input command codes (carried in s_axis_tuser)
    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_MODE_FWD = 2'd1;
    localparam logic [1:0] CMD_MODE_BWD = 2'd2;

    // Joystick modes
    localparam logic [1:0] MODE_MOUSE  = 2'd0;
    localparam logic [1:0] MODE_SCROLL = 2'd1;
    localparam logic [1:0] MODE_AXIS   = 2'd2;
    localparam logic [1:0] MODE_KEYS   = 2'd3;

    // Event kinds
    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_AXIS    = 2'd2;

    // Key codes
    localparam logic [2:0] KEY_W           = 3'd0;
    localparam logic [2:0] KEY_S           = 3'd1;
    localparam logic [2:0] KEY_D           = 3'd2;
    localparam logic [2:0] KEY_A           = 3'd3;
    localparam logic [2:0] KEY_WHEEL_UP    = 3'd4;
    localparam logic [2:0] KEY_WHEEL_DOWN  = 3'd5;
    localparam logic [2:0] KEY_WHEEL_RIGHT = 3'd6;
    localparam logic [2:0] KEY_WHEEL_LEFT  = 3'd7;
    localparam logic [2:0] KEY_NONE        = 3'd0;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 15;
    localparam logic [2:0] CFG_PRESS_HIGH = 3'd0;
    localparam logic [2:0] CFG_PRESS_LOW  = 3'd1;
    localparam logic [2:0] CFG_AXIS_MIN   = 3'd2;
    localparam logic [2:0] CFG_AXIS_MAX   = 3'd3;
    localparam logic [2:0] CFG_FULL_SCALE = 3'd4;
    localparam logic [2:0] CFG_X_REST     = 3'd5;
    localparam logic [2:0] CFG_Y_REST     = 3'd6;

    // Configuration reset values
    localparam logic [9:0]  RST_PRESS_HIGH = 10'd768;
    localparam logic [9:0]  RST_PRESS_LOW  = 10'd256;
    localparam logic [9:0]  RST_AXIS_MIN   = 10'd0;
    localparam logic [9:0]  RST_AXIS_MAX   = 10'd1023;
    localparam logic [14:0] RST_FULL_SCALE = 15'd127;
    localparam logic [9:0]  RST_X_REST     = 10'd512;
    localparam logic [9:0]  RST_Y_REST     = 10'd512;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic mode_fwd;
        logic mode_bwd;
        logic push_y;
        logic push_x;
        logic prep;
        logic mul;
        logic div_start;
        logic push_axis;
    } jkm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] mode;
        logic       y_evt;
        logic       x_evt;
        logic       div_busy;
        logic       out_free;
    } jkm_status_t;

endpackage

/* rtl/joystick_axis_key_mapper_core.sv */
// ----------------------------------------------------------------------------
// joystick_axis_key_mapper_core: joystick samples to key, wheel or axis events
// Streaming block turning X/Y ADC ticks into key transitions or coordinates.
// ----------------------------------------------------------------------------
// Each input transaction is a sample tick or a mode step. A mode step
// yields nothing. In direction-key and scroll modes a tick yields up to two
// press/release results (Y first, then X); in axis mode it yields one axis
// report, computed by the restoring dividers that develop one quotient bit
// per cycle, one per axis, running side by side. Mouse mode ticks yield
// nothing. The block works on one transaction at a time, but takes the next
// one while a finished result still waits in the output register. Write
// configuration only while the block is idle.
// ----------------------------------------------------------------------------
module joystick_axis_key_mapper_core #(
    parameter int SAMPLE_BITS = 10,
    parameter int AXIS_BITS   = 16,
    localparam int IN_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((3 + 2 * AXIS_BITS + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port
    input  logic                              cfg_wr_en,
    input  logic [jkm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [jkm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // Input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [IN_W-1:0]                   s_axis_tdata,  // x_sample, y_sample, zero pad
    input  logic [1:0]                        s_axis_tuser,  // command
    // Result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [OUT_W-1:0]                  m_axis_tdata,  // key_code, axis_x_value,
                                                             // axis_y_value, zero pad
    output logic [1:0]                        m_axis_tuser,  // event_kind
    output logic                              m_axis_tlast   // last_of_run
);

    import jkm_pkg::*;

    jkm_cmd_t    cmd;
    jkm_status_t status;

    logic [SAMPLE_BITS-1:0] in_x, in_y;
    logic [2:0]             out_key;
    logic [AXIS_BITS-1:0]   out_ax, out_ay;

    // Unpack the sample fields; the pad bits are ignored
    assign in_x = s_axis_tdata[SAMPLE_BITS-1:0];
    assign in_y = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

    // Sequence each transaction
    jkm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_cmd   (s_axis_tuser),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold configuration, mode, flags; compute and register the results
    jkm_datapath #(.SB(SAMPLE_BITS), .AB(AXIS_BITS)) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_x      (in_x),
        .in_y      (in_y),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_kind  (m_axis_tuser),
        .out_key   (out_key),
        .out_ax    (out_ax),
        .out_ay    (out_ay),
        .out_last  (m_axis_tlast)
    );

    // Pack the result fields, lowest first, zero filled to whole bytes
    assign m_axis_tdata = OUT_W'({out_ay, out_ax, out_key});

endmodule

/* rtl/jkm_div.sv */
// ----------------------------------------------------------------------------
// jkm_div: restoring divider, one quotient bit per cycle
// Expects the numerator's upper part to be below the denominator, so only
// the low quotient bits need developing.
// ----------------------------------------------------------------------------
module jkm_div #(
    parameter int SB = 10,
    parameter int QB = 15
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SB+QB-1:0] numer,
    input  logic [SB-1:0]    denom,
    output logic             busy,
    output logic [QB-1:0]    quot
);

    localparam int CNT_W = $clog2(QB + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SB-1:0]    rem_reg, rem_next;
    logic [QB-1:0]    low_reg, low_next;
    logic [SB-1:0]    den_reg, den_next;
    logic [SB:0]      rem_shift;
    logic [SB:0]      rem_diff;
    logic             ge;

    always_comb begin
        rem_shift = {rem_reg, low_reg[QB-1]};
        ge        = rem_shift >= {1'b0, den_reg};
        rem_diff  = rem_shift - {1'b0, den_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QB);
            rem_next  = numer[SB+QB-1:QB];
            low_next  = numer[QB-1:0];
            den_next  = denom;
        end else if (busy_reg) begin
            rem_next = ge ? rem_diff[SB-1:0] : rem_shift[SB-1:0];
            low_next = {low_reg[QB-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        low_reg <= low_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quot = low_reg;

endmodule

/* rtl/jkm_datapath.sv */
// ----------------------------------------------------------------------------
// jkm_datapath: registers, key chains, coordinate arithmetic, output stage
// Holds configuration, mode and held flags, evaluates both key chains,
// prepares and divides the axis coordinates, and drives the result register.
// ----------------------------------------------------------------------------
module jkm_datapath #(
    parameter int SB = 10,
    parameter int AB = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [jkm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [jkm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [SB-1:0]                      in_x,
    input  logic [SB-1:0]                      in_y,
    input  jkm_pkg::jkm_cmd_t                  cmd,
    output jkm_pkg::jkm_status_t               status,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic [1:0]                         out_kind,
    output logic [2:0]                         out_key,
    output logic signed [AB-1:0]               out_ax,
    output logic signed [AB-1:0]               out_ay,
    output logic                               out_last
);

    import jkm_pkg::*;

    localparam int QB = AB - 1;
    localparam logic [14:0] FULL_MAX = 15'((32'd1 << QB) - 32'd1);

    typedef struct packed {
        logic       evt;
        logic [1:0] kind;
        logic       neg;
        logic       hi;
        logic       lo;
    } key_res_t;

    typedef struct packed {
        logic          zero;
        logic          sat;
        logic          neg;
        logic [SB-1:0] delta;
        logic [SB-1:0] span;
    } coord_prep_t;

    function automatic logic [SB-1:0] fit(input logic [9:0] v);
        logic [SB+9:0] t;
        t = {{SB{1'b0}}, v};
        return t[SB-1:0];
    endfunction

    function automatic key_res_t key_chain(input logic [SB-1:0] s, input logic hi,
                                           input logic lo, input logic [SB-1:0] th,
                                           input logic [SB-1:0] tl);
        key_res_t r;
        r = '{evt: 1'b1, kind: KIND_PRESS, neg: 1'b0, hi: hi, lo: lo};
        priority if (!hi && s >= th) begin
            r.hi = 1'b1;
        end else if (hi && s < th) begin
            r.hi   = 1'b0;
            r.kind = KIND_RELEASE;
        end else if (!lo && s <= tl) begin
            r.lo  = 1'b1;
            r.neg = 1'b1;
        end else if (lo && s > tl) begin
            r.lo   = 1'b0;
            r.neg  = 1'b1;
            r.kind = KIND_RELEASE;
        end else begin
            r.evt = 1'b0;
        end
        return r;
    endfunction

    function automatic coord_prep_t coord_prep(input logic [SB-1:0] pos,
                                               input logic [SB-1:0] org,
                                               input logic [SB-1:0] mn,
                                               input logic [SB-1:0] mx);
        coord_prep_t c;
        c = '{zero: 1'b0, sat: 1'b0, neg: 1'b0, delta: '0, span: '0};
        priority if (pos == org) begin
            c.zero = 1'b1;
        end else if (org > pos) begin
            c.neg   = 1'b1;
            c.delta = org - pos;
            c.zero  = mn > org;
            c.span  = org - mn;
        end else begin
            c.delta = pos - org;
            c.zero  = mx < org;
            c.span  = mx - org;
        end
        // Zero span falls in here too: saturate to full scale
        c.sat = !c.zero && (c.delta >= c.span);
        return c;
    endfunction

    // Configuration
    logic [9:0]  press_high_reg, press_high_next;
    logic [9:0]  press_low_reg, press_low_next;
    logic [9:0]  axis_min_reg, axis_min_next;
    logic [9:0]  axis_max_reg, axis_max_next;
    logic [14:0] full_scale_reg, full_scale_next;
    logic [9:0]  x_rest_reg, x_rest_next;
    logic [9:0]  y_rest_reg, y_rest_next;

    // State
    logic [1:0]  mode_reg, mode_next;
    logic        y_hi_reg, y_hi_next, y_lo_reg, y_lo_next;
    logic        x_hi_reg, x_hi_next, x_lo_reg, x_lo_next;
    logic [SB-1:0] x_reg, x_next, y_reg, y_next;

    // Coordinate pipeline
    coord_prep_t   cx_reg, cx_next, cy_reg, cy_next;
    logic [SB+QB-1:0] px_reg, px_next, py_reg, py_next;
    logic [QB-1:0] full;
    logic [QB-1:0] qx, qy;
    logic          bx, by;
    logic [QB-1:0] mag_x, mag_y;
    logic [AB-1:0] val_x, val_y;

    // Key chains
    key_res_t yres, xres;
    logic [2:0] ykey_pos, ykey_neg, xkey_pos, xkey_neg;

    // Output register
    logic          valid_reg, valid_next;
    logic [1:0]    kind_reg, kind_next;
    logic [2:0]    key_reg, key_next;
    logic [AB-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic          last_reg, last_next;
    logic          out_free;

    assign full = (full_scale_reg > FULL_MAX) ? FULL_MAX[QB-1:0] : full_scale_reg[QB-1:0];

    always_comb begin
        yres = key_chain(y_reg, y_hi_reg, y_lo_reg, fit(press_high_reg), fit(press_low_reg));
        xres = key_chain(x_reg, x_hi_reg, x_lo_reg, fit(press_high_reg), fit(press_low_reg));
        if (mode_reg == MODE_SCROLL) begin
            ykey_pos = KEY_WHEEL_UP;
            ykey_neg = KEY_WHEEL_DOWN;
            xkey_pos = KEY_WHEEL_RIGHT;
            xkey_neg = KEY_WHEEL_LEFT;
        end else begin
            ykey_pos = KEY_W;
            ykey_neg = KEY_S;
            xkey_pos = KEY_D;
            xkey_neg = KEY_A;
        end
    end

    // Configuration writes
    always_comb begin
        press_high_next = press_high_reg;
        press_low_next  = press_low_reg;
        axis_min_next   = axis_min_reg;
        axis_max_next   = axis_max_reg;
        full_scale_next = full_scale_reg;
        x_rest_next     = x_rest_reg;
        y_rest_next     = y_rest_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PRESS_HIGH: press_high_next = cfg_wdata[9:0];
                CFG_PRESS_LOW:  press_low_next  = cfg_wdata[9:0];
                CFG_AXIS_MIN:   axis_min_next   = cfg_wdata[9:0];
                CFG_AXIS_MAX:   axis_max_next   = cfg_wdata[9:0];
                CFG_FULL_SCALE: full_scale_next = cfg_wdata;
                CFG_X_REST:     x_rest_next     = cfg_wdata[9:0];
                CFG_Y_REST:     y_rest_next     = cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    // Mode, flags, captured samples, coordinate preparation
    always_comb begin
        mode_next = mode_reg;
        y_hi_next = y_hi_reg;
        y_lo_next = y_lo_reg;
        x_hi_next = x_hi_reg;
        x_lo_next = x_lo_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        px_next   = px_reg;
        py_next   = py_reg;
        if (cmd.mode_fwd) begin
            mode_next = mode_reg + 2'd1;
        end else if (cmd.mode_bwd) begin
            mode_next = mode_reg - 2'd1;
        end
        if (cmd.capture) begin
            x_next = in_x;
            y_next = in_y;
        end
        if (cmd.push_y) begin
            y_hi_next = yres.hi;
            y_lo_next = yres.lo;
        end
        if (cmd.push_x) begin
            x_hi_next = xres.hi;
            x_lo_next = xres.lo;
        end
        if (cmd.prep) begin
            cx_next = coord_prep(x_reg, fit(x_rest_reg), fit(axis_min_reg), fit(axis_max_reg));
            cy_next = coord_prep(y_reg, fit(y_rest_reg), fit(axis_min_reg), fit(axis_max_reg));
        end
        if (cmd.mul) begin
            px_next = cx_reg.delta * full;
            py_next = cy_reg.delta * full;
        end
    end

    jkm_div #(.SB(SB), .QB(QB)) u_div_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .numer   (px_reg),
        .denom   (cx_reg.span),
        .busy    (bx),
        .quot    (qx)
    );

    jkm_div #(.SB(SB), .QB(QB)) u_div_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .numer   (py_reg),
        .denom   (cy_reg.span),
        .busy    (by),
        .quot    (qy)
    );

    always_comb begin
        mag_x = cx_reg.zero ? '0 : (cx_reg.sat ? full : qx);
        mag_y = cy_reg.zero ? '0 : (cy_reg.sat ? full : qy);
        val_x = cx_reg.neg ? -{1'b0, mag_x} : {1'b0, mag_x};
        // Y is reported negated
        val_y = cy_reg.neg ? {1'b0, mag_y} : -{1'b0, mag_y};
    end

    // Output register
    assign out_free = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        kind_next  = kind_reg;
        key_next   = key_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        last_next  = last_reg;
        if (out_ready) begin
            valid_next = 1'b0;
        end
        if (cmd.push_y) begin
            valid_next = 1'b1;
            kind_next  = yres.kind;
            key_next   = yres.neg ? ykey_neg : ykey_pos;
            ax_next    = '0;
            ay_next    = '0;
            last_next  = !xres.evt;
        end else if (cmd.push_x) begin
            valid_next = 1'b1;
            kind_next  = xres.kind;
            key_next   = xres.neg ? xkey_neg : xkey_pos;
            ax_next    = '0;
            ay_next    = '0;
            last_next  = 1'b1;
        end else if (cmd.push_axis) begin
            valid_next = 1'b1;
            kind_next  = KIND_AXIS;
            key_next   = KEY_NONE;
            ax_next    = val_x;
            ay_next    = val_y;
            last_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_high_reg <= RST_PRESS_HIGH;
            press_low_reg  <= RST_PRESS_LOW;
            axis_min_reg   <= RST_AXIS_MIN;
            axis_max_reg   <= RST_AXIS_MAX;
            full_scale_reg <= RST_FULL_SCALE;
            x_rest_reg     <= RST_X_REST;
            y_rest_reg     <= RST_Y_REST;
            mode_reg       <= MODE_KEYS;
            y_hi_reg       <= 1'b0;
            y_lo_reg       <= 1'b0;
            x_hi_reg       <= 1'b0;
            x_lo_reg       <= 1'b0;
            valid_reg      <= 1'b0;
        end else begin
            press_high_reg <= press_high_next;
            press_low_reg  <= press_low_next;
            axis_min_reg   <= axis_min_next;
            axis_max_reg   <= axis_max_next;
            full_scale_reg <= full_scale_next;
            x_rest_reg     <= x_rest_next;
            y_rest_reg     <= y_rest_next;
            mode_reg       <= mode_next;
            y_hi_reg       <= y_hi_next;
            y_lo_reg       <= y_lo_next;
            x_hi_reg       <= x_hi_next;
            x_lo_reg       <= x_lo_next;
            valid_reg      <= valid_next;
        end
        x_reg    <= x_next;
        y_reg    <= y_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        kind_reg <= kind_next;
        key_reg  <= key_next;
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        last_reg <= last_next;
    end

    assign status = '{mode: mode_reg, y_evt: yres.evt, x_evt: xres.evt,
                      div_busy: bx | by, out_free: out_free};

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_key   = key_reg;
    assign out_ax    = ax_reg;
    assign out_ay    = ay_reg;
    assign out_last  = last_reg;

endmodule

/* rtl/jkm_ctrl.sv */
// ----------------------------------------------------------------------------
// jkm_ctrl: sequencing state machine
// Takes one transaction at a time, then walks the key events or the
// coordinate computation, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module jkm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic [1:0]            in_cmd,
    output logic                  in_ready,
    input  jkm_pkg::jkm_status_t  status,
    output jkm_pkg::jkm_cmd_t     cmd
);

    import jkm_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_KEY_Y = 8'b0000_0010,
        ST_KEY_X = 8'b0000_0100,
        ST_PREP  = 8'b0000_1000,
        ST_MUL   = 8'b0001_0000,
        ST_LOAD  = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    priority if (in_cmd == CMD_MODE_FWD) begin
                        cmd.mode_fwd = 1'b1;
                    end else if (in_cmd == CMD_MODE_BWD) begin
                        cmd.mode_bwd = 1'b1;
                    end else if (in_cmd == CMD_TICK) begin
                        if (status.mode == MODE_KEYS || status.mode == MODE_SCROLL) begin
                            state_next = ST_KEY_Y;
                        end else if (status.mode == MODE_AXIS) begin
                            state_next = ST_PREP;
                        end
                    end else begin
                        // unused command code: drop
                    end
                end
            end
            ST_KEY_Y: begin
                if (!status.y_evt) begin
                    state_next = ST_KEY_X;
                end else if (status.out_free) begin
                    cmd.push_y = 1'b1;
                    state_next = ST_KEY_X;
                end
            end
            ST_KEY_X: begin
                if (!status.x_evt) begin
                    state_next = ST_IDLE;
                end else if (status.out_free) begin
                    cmd.push_x = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (!status.div_busy) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.push_axis = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
